// File: design/wwc_pkg.sv
package wwc_pkg;

   localparam int ELAPSED_W   = 18;
   localparam int PULSE_W     = 12;
   localparam int DEG_W       = 9;
   localparam int SCALE_W     = 20;
   localparam int SPEED_W     = 16;
   localparam int SPEED_SUM_W = 22;
   localparam int DIR_SUM_W   = 15;
   localparam int INDEX_W     = 6;
   localparam int ADJ_W       = 11;

   localparam int WINDOW_SAMPLES = 60;

   localparam int DIV_NUM_W = PULSE_W + SCALE_W;
   localparam int DIV_DEN_W = ELAPSED_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   // floor(x / WINDOW_SAMPLES) = (x * ceil(2^28 / WINDOW_SAMPLES)) >> 28 for x < 2^22
   localparam int RECIP_SHIFT  = 28;
   localparam int RECIP_W      = RECIP_SHIFT + 1;
   localparam int SPEED_PROD_W = SPEED_SUM_W + RECIP_W;
   localparam int DIR_PROD_W   = DIR_SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] WINDOW_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW_SAMPLES - 1)) / 64'(WINDOW_SAMPLES));

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = SCALE_W;

   localparam logic [CSR_INDEX_W-1:0] REG_POINTER_OFFSET = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_SPEED_SCALE    = CSR_INDEX_W'(1);

   localparam logic [DEG_W-1:0]   POINTER_OFFSET_RESET = DEG_W'(264);
   localparam logic [SCALE_W-1:0] SPEED_SCALE_RESET    = SCALE_W'(314620);

   localparam logic [ADJ_W-1:0]   DEG_FULL   = ADJ_W'(360);
   localparam logic [ADJ_W-1:0]   DEG_TWICE  = ADJ_W'(720);
   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(WINDOW_SAMPLES - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b0_0001,
      ST_START = 5'b0_0010,
      ST_DIV   = 5'b0_0100,
      ST_ACC   = 5'b0_1000,
      ST_EMIT  = 5'b1_0000
   } state_type;

   typedef struct packed {
      logic load;
      logic dir_step;
      logic start_div;
      logic accumulate;
      logic emit;
   } wwc_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic last_sample;
   } wwc_status_type;

endpackage

// File: design/wwc_if.sv
interface wwc_req_if import wwc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ELAPSED_W-1:0] elapsed_ms;
   logic [PULSE_W-1:0]   pulse_count;
   logic [DEG_W-1:0]     vane_angle_deg;
   logic [DEG_W-1:0]     compass_deg;

   modport source (output valid, elapsed_ms, pulse_count, vane_angle_deg, compass_deg,
                   input ready);
   modport sink (input valid, elapsed_ms, pulse_count, vane_angle_deg, compass_deg,
                 output ready);
endinterface

interface wwc_rsp_if import wwc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SPEED_W-1:0] avg_speed_cmph;
   logic [SPEED_W-1:0] gust_cmph;
   logic [DEG_W-1:0]   avg_direction_deg;

   modport source (output valid, avg_speed_cmph, gust_cmph, avg_direction_deg,
                   input ready);
   modport sink (input valid, avg_speed_cmph, gust_cmph, avg_direction_deg,
                 output ready);
endinterface

interface wwc_csr_if import wwc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: design/wwc_div.sv
module wwc_div import wwc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 busy,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quot
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] dvd_ff, dvd_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_shift;
   logic [DIV_DEN_W:0]   rem_diff;
   logic                 ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_shift = {rem_ff, dvd_ff[DIV_NUM_W-1]};
      ge        = rem_shift >= {1'b0, den_ff};
      rem_diff  = rem_shift - {1'b0, den_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W - 1);
         dvd_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_NUM_W-2:0], ge};
         rem_in = ge ? rem_diff[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = dvd_ff;

endmodule

// File: design/wwc_datapath.sv
module wwc_datapath import wwc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  wwc_cmd_type            cmd,
   output wwc_status_type         status,
   input  logic [ELAPSED_W-1:0]   req_elapsed_ms,
   input  logic [PULSE_W-1:0]     req_pulse_count,
   input  logic [DEG_W-1:0]       req_vane_angle_deg,
   input  logic [DEG_W-1:0]       req_compass_deg,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic [SPEED_W-1:0]     rsp_avg_speed_cmph,
   output logic [SPEED_W-1:0]     rsp_gust_cmph,
   output logic [DEG_W-1:0]       rsp_avg_direction_deg
);

   function automatic logic [DEG_W-1:0] mod_deg(input logic [ADJ_W-1:0] v);
      logic [ADJ_W-1:0] r;
      r = v;
      for (int i = 0; i < 3; i++) begin
         if (r >= DEG_FULL) r = r - DEG_FULL;
      end
      return r[DEG_W-1:0];
   endfunction

   logic [DEG_W-1:0]       offset_ff;
   logic [SCALE_W-1:0]     scale_ff;
   logic [DIV_NUM_W-1:0]   product_ff;
   logic [ELAPSED_W-1:0]   elapsed_ff;
   logic                   elapsed_zero_ff;
   logic [DEG_W-1:0]       adj_ff;
   logic [DEG_W-1:0]       compass_ff;
   logic [DEG_W-1:0]       dir_ff;
   logic [INDEX_W-1:0]     index_ff;
   logic [SPEED_SUM_W-1:0] speed_sum_ff;
   logic [SPEED_W-1:0]     gust_ff;
   logic [DIR_SUM_W-1:0]   dir_sum_ff;
   logic [SPEED_W-1:0]     rsp_speed_ff;
   logic [SPEED_W-1:0]     rsp_gust_ff;
   logic [DEG_W-1:0]       rsp_dir_ff;

   logic [ADJ_W-1:0]        adj_raw;
   logic [DIV_NUM_W-1:0]    quot;
   logic [SPEED_W-1:0]      speed;
   logic [SPEED_PROD_W-1:0] speed_prod;
   logic [DIR_PROD_W-1:0]   dir_prod;

   assign adj_raw = ADJ_W'(req_vane_angle_deg) + DEG_TWICE - ADJ_W'(offset_ff);

   wwc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.start_div),
      .num   (product_ff),
      .den   (elapsed_ff),
      .busy  (status.div_busy),
      .done  (status.div_done),
      .quot  (quot)
   );

   always_comb begin
      if (elapsed_zero_ff) speed = '0;
      else if (quot[DIV_NUM_W-1:SPEED_W] != '0) speed = '1;
      else speed = quot[SPEED_W-1:0];
   end

   // window averages by reciprocal multiply
   assign speed_prod = SPEED_PROD_W'(speed_sum_ff) * SPEED_PROD_W'(WINDOW_RECIP);
   assign dir_prod   = DIR_PROD_W'(dir_sum_ff) * DIR_PROD_W'(WINDOW_RECIP);

   assign status.last_sample = index_ff == LAST_INDEX;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= POINTER_OFFSET_RESET;
         scale_ff  <= SPEED_SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_POINTER_OFFSET: offset_ff <= csr_data[DEG_W-1:0];
            REG_SPEED_SCALE:    scale_ff  <= csr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         product_ff      <= DIV_NUM_W'(req_pulse_count) * DIV_NUM_W'(scale_ff);
         elapsed_ff      <= req_elapsed_ms;
         elapsed_zero_ff <= req_elapsed_ms == '0;
         adj_ff          <= mod_deg(adj_raw);
         compass_ff      <= req_compass_deg;
      end
      if (cmd.dir_step) dir_ff <= mod_deg(ADJ_W'(compass_ff) + ADJ_W'(adj_ff));
      if (cmd.emit) begin
         rsp_speed_ff <= speed_prod[RECIP_SHIFT+SPEED_W-1:RECIP_SHIFT];
         rsp_gust_ff  <= gust_ff;
         rsp_dir_ff   <= dir_prod[RECIP_SHIFT+DEG_W-1:RECIP_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         index_ff     <= '0;
         speed_sum_ff <= '0;
         gust_ff      <= '0;
         dir_sum_ff   <= '0;
      end else if (cmd.accumulate) begin
         index_ff     <= index_ff + 1'b1;
         speed_sum_ff <= speed_sum_ff + SPEED_SUM_W'(speed);
         dir_sum_ff   <= dir_sum_ff + DIR_SUM_W'(dir_ff);
         if (speed > gust_ff) gust_ff <= speed;
      end
   end

   assign rsp_avg_speed_cmph    = rsp_speed_ff;
   assign rsp_gust_cmph         = rsp_gust_ff;
   assign rsp_avg_direction_deg = rsp_dir_ff;

endmodule

// File: design/wwc_ctrl.sv
module wwc_ctrl import wwc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  wwc_status_type status,
   output wwc_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.start_div = 1'b1;
            cmd.dir_step  = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.accumulate = 1'b1;
            state_in       = status.last_sample ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> cmd.start_div)
      else $error("accepted word did not start the divider");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emitted result not presented");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> !req_ready)
      else $error("input ready while divider busy");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the wait state");
`endif

endmodule

// File: design/wind_window_consolidator.sv
// Wind window consolidator.
// req_if: one word per 10 s anemometer sample (elapsed ms, cup pulses,
//   vane angle, compass heading). Accepted when valid and ready are high.
// rsp_if: one word per window of 60 samples: average speed, gust and mean
//   direction. Nothing is produced for the other samples.
// csr_if: register writes, index 0 pointer offset, index 1 speed scale;
//   always ready, unknown indexes are dropped. Write only while idle.
// A sample occupies the block while the radix-2 divider computes
//   pulses*scale/elapsed; the next word is accepted only after the sample
//   has been accumulated and the block is idle again.
// The last sample of a window adds an emit state: the averages come from
//   reciprocal multiplies and the result is registered in that state;
//   the next word can follow once the result has been registered.
// The result sits in an output register; a stalled receiver holds it and
//   only blocks the block when the next window result is ready to load.
// Reset restores the registers to their defaults (offset 264, scale
//   314620), clears the accumulators and drops any pending result.
module wind_window_consolidator import wwc_pkg::*; (
   input logic clock,
   input logic reset,
   wwc_req_if.sink   req_if,
   wwc_rsp_if.source rsp_if,
   wwc_csr_if.sink   csr_if
);

   wwc_cmd_type    cmd;
   wwc_status_type status;
   logic           req_ready;
   logic           rsp_valid;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;

   wwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wwc_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_elapsed_ms        (req_if.elapsed_ms),
      .req_pulse_count       (req_if.pulse_count),
      .req_vane_angle_deg    (req_if.vane_angle_deg),
      .req_compass_deg       (req_if.compass_deg),
      .csr_we                (csr_if.valid),
      .csr_index             (csr_if.index),
      .csr_data              (csr_if.data),
      .rsp_avg_speed_cmph    (rsp_if.avg_speed_cmph),
      .rsp_gust_cmph         (rsp_if.gust_cmph),
      .rsp_avg_direction_deg (rsp_if.avg_direction_deg)
   );

endmodule
